/* src/gwp_pkg.sv */
`timescale 1ns / 1ps
// Package for the G-code word parser: character codes, parse modes, defaults.
// No dependencies.
package gwp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int SPEED_RESET     = 100;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_Z       = 8'h5A;

  // cell size shifts for the moved check (x cell 4, y cell 8)
  localparam int X_CELL_SHIFT = 2;
  localparam int Y_CELL_SHIFT = 3;

  typedef enum logic [2:0] {
    M_LINE_START = 3'd0,
    M_WORD_START = 3'd1,
    M_PRESIGN    = 3'd2,
    M_SIGNED     = 3'd3,
    M_DIGITS     = 3'd4,
    M_DROP       = 3'd5,
    M_STOP       = 3'd6,
    M_COMMENT    = 3'd7
  } mode_t;

endpackage

/* src/gcode_word_parser_top.sv */
`timescale 1ns / 1ps
// G-code word parser top level: character parser, word registers, result register.
// Depends on gwp_pkg.
//
// Takes one character word per clock on the input channel and emits one result word
// (x, y, z, feed, speed, moved) the cycle after the newline of each non-comment line is
// accepted. The digit accumulate (times ten, add, saturate) and the word commit to the
// position registers are done in the accept cycle. The input stalls only while a
// finished result sits in the output register and the output side is stalling;
// otherwise a character is taken every cycle. Values saturate to the signed range
// of VALUE_WIDTH and the outputs carry their low 32 bits (sign extended when
// VALUE_WIDTH is narrower than 32).
module gcode_word_parser_top #(
  parameter int VALUE_WIDTH = gwp_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] feed_rate,
  output logic signed [31:0] spindle_speed,
  output logic               moved
);

  localparam int VW    = VALUE_WIDTH;
  localparam int SUM_W = VW + 4;
  localparam int EXT_W = (VW > gwp_pkg::OUT_WIDTH) ? VW : gwp_pkg::OUT_WIDTH;
  localparam logic [VW-1:0] MAG_LIM = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};

  gwp_pkg::mode_t mode, mode_next;
  logic [7:0]     letter, letter_next;
  logic           neg, neg_next;
  logic [VW-1:0]  acc, acc_next;
  logic signed [VW-1:0] reg_x, reg_y, reg_z, reg_feed, reg_speed;
  logic signed [VW-1:0] reg_x_next, reg_y_next, reg_z_next, reg_feed_next, reg_speed_next;
  logic           moved_flag, moved_flag_next;

  logic           accept;
  logic           is_nl, is_space, is_semi, is_dot, is_sign, is_digit, is_ws;
  logic           do_finish, do_emit, clr_moved;
  logic [SUM_W-1:0] acc_x10;
  logic [VW-1:0]  acc_sat;
  logic signed [VW-1:0] wval;
  logic           moved_set, moved_line;

  function automatic logic [VW-1:0] cell_of(input logic [VW-1:0] v, input int sh);
    logic [VW-1:0] bias;
    bias = v[VW-1] ? VW'((1 << sh) - 1) : '0;
    return VW'($signed(v + bias) >>> sh);
  endfunction

  function automatic logic [31:0] low_out(input logic signed [VW-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[31:0];
  endfunction

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_nl    = (char_code == gwp_pkg::CH_NEWLINE);
  assign is_space = (char_code == gwp_pkg::CH_SPACE);
  assign is_semi  = (char_code == gwp_pkg::CH_SEMI);
  assign is_dot   = (char_code == gwp_pkg::CH_DOT);
  assign is_sign  = (char_code == gwp_pkg::CH_PLUS) || (char_code == gwp_pkg::CH_MINUS);
  assign is_digit = (char_code >= gwp_pkg::CH_ZERO) && (char_code <= gwp_pkg::CH_NINE);
  assign is_ws    = (char_code == gwp_pkg::CH_TAB) || (char_code == gwp_pkg::CH_VTAB) ||
                    (char_code == gwp_pkg::CH_FF) || (char_code == gwp_pkg::CH_CR);

  // acc*10 + digit, saturating at the magnitude limit
  assign acc_x10 = (SUM_W'(acc) << 3) + (SUM_W'(acc) << 1) + SUM_W'(char_code[3:0]);
  assign acc_sat = (acc_x10 > SUM_W'(MAG_LIM)) ? MAG_LIM : acc_x10[VW-1:0];

  // acc never exceeds MAG_LIM, so negation always fits
  assign wval = neg ? $signed(VW'(~acc + 1'b1))
                    : ((acc > POS_MAX) ? $signed(POS_MAX) : $signed(acc));

  always_comb begin
    mode_next   = mode;
    letter_next = letter;
    neg_next    = neg;
    acc_next    = acc;
    do_finish   = 1'b0;
    do_emit     = 1'b0;
    clr_moved   = 1'b0;
    if (accept) begin
      unique case (mode)
        gwp_pkg::M_COMMENT: begin
          if (is_nl) begin
            mode_next = gwp_pkg::M_LINE_START;
            clr_moved = 1'b1;
          end
        end
        gwp_pkg::M_LINE_START, gwp_pkg::M_WORD_START: begin
          if (mode == gwp_pkg::M_LINE_START && is_semi) begin
            mode_next = gwp_pkg::M_COMMENT;
          end else if (is_nl) begin
            do_emit = 1'b1;
          end else if (is_space) begin
            mode_next = gwp_pkg::M_WORD_START;
          end else if (is_semi) begin
            mode_next = gwp_pkg::M_STOP;
          end else if (is_dot) begin
            letter_next = '0;
            mode_next   = gwp_pkg::M_DROP;
          end else begin
            letter_next = char_code;
            mode_next   = gwp_pkg::M_PRESIGN;
          end
        end
        gwp_pkg::M_STOP: begin
          if (is_nl) begin
            do_emit = 1'b1;
          end
        end
        gwp_pkg::M_PRESIGN, gwp_pkg::M_SIGNED, gwp_pkg::M_DIGITS, gwp_pkg::M_DROP: begin
          if (is_space) begin
            do_finish   = 1'b1;
            letter_next = '0;
            neg_next    = 1'b0;
            acc_next    = '0;
            mode_next   = gwp_pkg::M_WORD_START;
          end else if (is_nl) begin
            do_finish = 1'b1;
            do_emit   = 1'b1;
          end else if (mode == gwp_pkg::M_PRESIGN && is_ws) begin
            mode_next = mode;
          end else if (mode == gwp_pkg::M_PRESIGN && is_sign) begin
            neg_next  = (char_code == gwp_pkg::CH_MINUS);
            mode_next = gwp_pkg::M_SIGNED;
          end else if (mode != gwp_pkg::M_DROP) begin
            if (is_digit) begin
              acc_next  = acc_sat;
              mode_next = gwp_pkg::M_DIGITS;
            end else begin
              mode_next = gwp_pkg::M_DROP;
            end
          end
        end
        default: mode_next = mode;
      endcase
      if (do_emit) begin
        letter_next = '0;
        neg_next    = 1'b0;
        acc_next    = '0;
        mode_next   = gwp_pkg::M_LINE_START;
      end
    end
  end

  // word commit
  always_comb begin
    reg_x_next     = reg_x;
    reg_y_next     = reg_y;
    reg_z_next     = reg_z;
    reg_feed_next  = reg_feed;
    reg_speed_next = reg_speed;
    moved_set      = 1'b0;
    if (do_finish) begin
      unique case (letter)
        gwp_pkg::CH_F: reg_feed_next = wval;
        gwp_pkg::CH_S: reg_speed_next = wval;
        gwp_pkg::CH_X: begin
          reg_x_next = wval;
          moved_set  = cell_of(reg_x, gwp_pkg::X_CELL_SHIFT) !=
                       cell_of(wval, gwp_pkg::X_CELL_SHIFT);
        end
        gwp_pkg::CH_Y: begin
          reg_y_next = wval;
          moved_set  = cell_of(reg_y, gwp_pkg::Y_CELL_SHIFT) !=
                       cell_of(wval, gwp_pkg::Y_CELL_SHIFT);
        end
        gwp_pkg::CH_Z: reg_z_next = wval;
        default: moved_set = 1'b0;
      endcase
    end
    moved_line      = moved_flag | moved_set;
    moved_flag_next = (do_emit || clr_moved) ? 1'b0 : moved_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= gwp_pkg::M_LINE_START;
      letter     <= '0;
      neg        <= 1'b0;
      acc        <= '0;
      reg_x      <= '0;
      reg_y      <= '0;
      reg_z      <= '0;
      reg_feed   <= '0;
      reg_speed  <= VW'(gwp_pkg::SPEED_RESET);
      moved_flag <= 1'b0;
    end else begin
      mode       <= mode_next;
      letter     <= letter_next;
      neg        <= neg_next;
      acc        <= acc_next;
      reg_x      <= reg_x_next;
      reg_y      <= reg_y_next;
      reg_z      <= reg_z_next;
      reg_feed   <= reg_feed_next;
      reg_speed  <= reg_speed_next;
      moved_flag <= moved_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      pos_x         <= low_out(reg_x_next);
      pos_y         <= low_out(reg_y_next);
      pos_z         <= low_out(reg_z_next);
      feed_rate     <= low_out(reg_feed_next);
      spindle_speed <= low_out(reg_speed_next);
      moved         <= moved_line;
    end
  end

endmodule

/* src/gwp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the G-code word parser, bound to the top level.
// Depends on gwp_pkg and gcode_word_parser_top.
module gwp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         char_code,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pos_x,
  input logic               moved
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(moved))
    else $error("stalled result changed");

  // input is only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // every new result follows an accepted newline
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && !($past(out_valid) && $past(out_stall)) |->
      $past(in_acc) && $past(char_code) == gwp_pkg::CH_NEWLINE)
    else $error("result without newline");

  // other characters never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_acc && char_code != gwp_pkg::CH_NEWLINE && !out_stall |=> !out_valid)
    else $error("result from non-newline character");

endmodule

bind gcode_word_parser_top gwp_checker u_gwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .char_code (char_code),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pos_x     (pos_x),
  .moved     (moved)
);
